// ===== rtl/core/diff_drive_odometry_assert.svh =====
// Assertion macros for the odometry block.
// Used by modules that carry aclk and aresetn; no other dependencies.
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ddo_pkg.sv =====
// Shared types and constants for the differential drive odometry block.
// No dependencies.
package ddo_pkg;

    localparam int MUL_W = 64;

    // register indexes
    localparam logic [1:0] REG_MPT  = 2'd0;
    localparam logic [1:0] REG_IWS  = 2'd1;
    localparam logic [1:0] REG_GAIN = 2'd2;

    localparam logic [31:0] MPT_RST  = 32'd4998100;
    localparam logic [23:0] IWS_RST  = 24'd219588;
    localparam logic [17:0] GAIN_RST = 18'd65536;

    // multiply sequence
    localparam logic [3:0] OP_DSUM = 4'd0;
    localparam logic [3:0] OP_P1   = 4'd1;
    localparam logic [3:0] OP_K    = 4'd2;
    localparam logic [3:0] OP_TURN = 4'd3;
    localparam logic [3:0] OP_HEAD = 4'd4;
    localparam logic [3:0] OP_LSPD = 4'd5;
    localparam logic [3:0] OP_ASPD = 4'd6;
    localparam logic [3:0] OP_XINC = 4'd7;
    localparam logic [3:0] OP_YINC = 4'd8;
    localparam logic [3:0] OP_LAST = OP_YINC;

    localparam logic [29:0] INV_TWO_PI = 30'd683565276;
    localparam logic [19:0] MEGA       = 20'd1000000;
    localparam logic [31:0] CORDIC_X0  = 32'd652032874;

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
        30'h00000001, 30'h00000000
    };

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       mul_go;
        logic [3:0] op;
        logic       div_go;
        logic       commit;
    } ddo_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic cordic_done;
        logic div_done;
    } ddo_sts_t;

endpackage

// ===== rtl/core/ddo_mul.sv =====
// 64x64 multiplier built from one 32x32 multiplier over four passes.
// Depends on ddo_pkg.
module ddo_mul import ddo_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   prod,
    output logic                 done
);
    logic [MUL_W-1:0]   a_reg, b_reg, pp_reg;
    logic [1:0]         sh_reg;
    logic               ppv_reg, busy_reg, done_reg;
    logic [2:0]         cnt_reg;
    logic [2*MUL_W-1:0] acc_reg, pp_shift;
    logic [31:0]        a_half, b_half;

    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        case (sh_reg)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd1:    pp_shift = {32'd0, pp_reg, 32'd0};
            default: pp_shift = {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                b_reg    <= b;
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
                ppv_reg  <= 1'b0;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg != 3'd4) begin
                    pp_reg  <= a_half * b_half;
                    sh_reg  <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                    ppv_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 3'd1;
                end else begin
                    ppv_reg <= 1'b0;
                end
                if (ppv_reg) begin
                    acc_reg <= acc_reg + pp_shift;
                    if (cnt_reg == 3'd4) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/ddo_cordic.sv =====
// Iterative CORDIC giving cosine and sine (Q2.30) of a binary angle.
// Depends on ddo_pkg for the arctangent table.
module ddo_cordic import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic signed [32:0] cos_out,
    output logic signed [32:0] sin_out,
    output logic               done
);
    localparam int STEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int CW    = $clog2(STEPS + 1);

    logic signed [32:0] x_reg, y_reg, x_sh, y_sh;
    logic signed [33:0] z_reg, z_in, z_fold, atan_v;
    logic               flip_reg, flip_in, busy_reg, done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [4:0]         idx;

    assign idx    = 5'(cnt_reg);
    assign x_sh   = x_reg >>> idx;
    assign y_sh   = y_reg >>> idx;
    assign atan_v = $signed({4'd0, ATAN_TAB[idx]});

    // fold into +-quarter turn
    always_comb begin
        z_in    = $signed({{2{angle[31]}}, angle});
        z_fold  = z_in;
        flip_in = 1'b0;
        if (z_in > 34'sd1073741824) begin
            z_fold  = z_in - 34'sd2147483648;
            flip_in = 1'b1;
        end else if (z_in < -34'sd1073741824) begin
            z_fold  = z_in + 34'sd2147483648;
            flip_in = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            x_reg    <= $signed({1'b0, CORDIC_X0});
            y_reg    <= '0;
            z_reg    <= z_fold;
            flip_reg <= flip_in;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_v;
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_v;
            end
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;
    assign done    = done_reg;

endmodule

// ===== rtl/core/ddo_ctrl.sv =====
// Sequencer for the odometry datapath: input word, multiply chain, divide, result.
// Depends on ddo_pkg and diff_drive_odometry_assert.svh.
`include "diff_drive_odometry_assert.svh"
module ddo_ctrl import ddo_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ddo_cmd_t cmd,
    input  ddo_sts_t sts
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DIVW  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [3:0] op_reg, op_next;
    logic       ovld_reg, ovld_next;
    logic       need_cordic;

    assign need_cordic = (op_reg == OP_XINC) || (op_reg == OP_YINC);
    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = ovld_reg;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        cmd.load   = s_tvalid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_PREP;
            ST_PREP: begin
                cmd.prep   = 1'b1;
                op_next    = OP_DSUM;
                state_next = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (!need_cordic || sts.cordic_done) begin
                    cmd.mul_go = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (sts.mul_done) begin
                    if (op_reg == OP_LAST) begin
                        state_next = ST_DIV;
                    end else begin
                        op_next    = op_reg + 4'd1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_go = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW:  if (sts.div_done) state_next = ST_DONE;
            ST_DONE: begin
                if (!ovld_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
        ovld_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : ovld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DSUM;
            ovld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ovld_reg  <= ovld_next;
        end
    end

    `DDO_ASSERT_NXT(a_accept_prep, s_tvalid && s_tready, state_reg == ST_PREP, "accept without prep")
    `DDO_ASSERT_NXT(a_mul_pulse, sts.mul_done, !sts.mul_done, "multiply done not a pulse")
    `DDO_ASSERT_IMP(a_commit_free, cmd.commit, !m_tvalid || m_tready, "result overwritten")
    `DDO_ASSERT_IMP(a_go_idle, cmd.mul_go || cmd.div_go, state_reg != ST_IDLE, "unit started idle")

endmodule

// ===== rtl/core/ddo_datapath.sv =====
// Odometry datapath: config, pose state, operand muxing, divider and result register.
// Depends on ddo_pkg, ddo_mul and ddo_cordic.
module ddo_datapath import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int COUNT_BITS   = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic [87:0]  s_tdata,
    output logic [191:0] m_tdata,
    output logic [0:0]   m_tuser,
    input  ddo_cmd_t     cmd,
    output ddo_sts_t     sts
);
    logic [31:0] mpt_reg;
    logic [23:0] iws_reg;
    logic [17:0] gain_reg;
    logic [31:0] left_reg, right_reg, prev_l_reg, prev_r_reg;
    logic [23:0] e_reg;
    logic [47:0] px_reg, py_reg;
    logic [31:0] hd_reg;
    logic [32:0] smag_reg, tmag_reg;
    logic        sneg_reg, tneg_reg;
    logic [62:0] dmag_reg, thmag_reg;
    logic [63:0] p1_reg;
    logic [41:0] k_reg;
    logic [66:0] n_reg [2];

    logic [31:0] dl, dr;
    logic signed [33:0] cl, cr, sv, tv;

    assign dl = left_reg - prev_l_reg;
    assign dr = right_reg - prev_r_reg;
    assign cl = $signed({{(34-COUNT_BITS){dl[COUNT_BITS-1]}}, dl[COUNT_BITS-1:0]});
    assign cr = $signed({{(34-COUNT_BITS){dr[COUNT_BITS-1]}}, dr[COUNT_BITS-1:0]});
    assign sv = cl + cr;
    assign tv = cl - cr;

    // cordic
    logic signed [32:0] cos_v, sin_v, comp;
    logic               cordic_done;
    ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.prep), .angle(hd_reg),
        .cos_out(cos_v), .sin_out(sin_v), .done(cordic_done)
    );

    // multiplier operands
    logic [63:0]  mul_a, mul_b;
    logic [127:0] prod;
    logic         mul_done;
    logic [32:0]  cabs;
    logic         cneg;

    assign comp = (cmd.op == OP_YINC) ? sin_v : cos_v;
    assign cneg = comp[32];
    assign cabs = cneg ? -comp : comp;

    always_comb begin
        mul_a = 64'd0;
        mul_b = 64'd0;
        unique case (cmd.op) inside
            OP_DSUM: begin mul_a = 64'(smag_reg); mul_b = 64'(mpt_reg); end
            OP_P1:   begin mul_a = 64'(tmag_reg); mul_b = 64'(mpt_reg); end
            OP_K:    begin mul_a = 64'(iws_reg);  mul_b = 64'(gain_reg); end
            OP_TURN: begin mul_a = p1_reg;        mul_b = 64'(k_reg); end
            OP_HEAD: begin mul_a = 64'(thmag_reg); mul_b = 64'(INV_TWO_PI); end
            OP_LSPD: begin mul_a = 64'(dmag_reg); mul_b = 64'(MEGA); end
            OP_ASPD: begin mul_a = 64'(thmag_reg); mul_b = 64'(MEGA); end
            OP_XINC, OP_YINC: begin mul_a = 64'(dmag_reg); mul_b = 64'(cabs[31:0]); end
            default: begin mul_a = 64'd0; mul_b = 64'd0; end
        endcase
    end

    ddo_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.mul_go),
        .a(mul_a), .b(mul_b), .prod(prod), .done(mul_done)
    );

    logic [47:0] inc;
    logic [31:0] hinc;
    assign inc  = prod[93:46];
    assign hinc = prod[63:32];

    // two-lane restoring divider, quotient of n / e
    logic [23:0] rem_reg [2];
    logic [31:0] q_reg [2];
    logic        sat_reg [2];
    logic        dbusy_reg, ddone_reg;
    logic [4:0]  dcnt_reg;
    logic [24:0] trial [2];
    logic [24:0] shl [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            shl[l]   = {rem_reg[l], q_reg[l][31]};
            trial[l] = shl[l] - {1'b0, e_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= 5'd0;
        end else begin
            ddone_reg <= 1'b0;
            if (cmd.div_go) begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= 5'd0;
                for (int l = 0; l < 2; l++) begin
                    sat_reg[l] <= (n_reg[l][66:32] >= {11'd0, e_reg});
                    rem_reg[l] <= n_reg[l][55:32];
                    q_reg[l]   <= n_reg[l][31:0];
                end
            end else if (dbusy_reg) begin
                for (int l = 0; l < 2; l++) begin
                    if (!trial[l][24]) begin
                        rem_reg[l] <= trial[l][23:0];
                        q_reg[l]   <= {q_reg[l][30:0], 1'b1};
                    end else begin
                        rem_reg[l] <= shl[l][23:0];
                        q_reg[l]   <= {q_reg[l][30:0], 1'b0};
                    end
                end
                dcnt_reg <= dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd31) begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
        end
    end

    // speed finish: saturate and sign
    logic [31:0] spd [2];
    logic        sneg_l [2];
    logic [31:0] lim, vmag;
    always_comb begin
        sneg_l[0] = sneg_reg && (dmag_reg != 63'd0);
        sneg_l[1] = tneg_reg && (thmag_reg != 63'd0);
        lim  = 32'h7FFF_FFFF;
        vmag = 32'd0;
        for (int l = 0; l < 2; l++) begin
            lim = sneg_l[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            vmag = (sat_reg[l] || (q_reg[l] > lim)) ? lim : q_reg[l];
            if (e_reg == 24'd0) spd[l] = 32'd0;
            else                spd[l] = sneg_l[l] ? -vmag : vmag;
        end
    end

    // config and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpt_reg    <= MPT_RST;
            iws_reg    <= IWS_RST;
            gain_reg   <= GAIN_RST;
            prev_l_reg <= 32'd0;
            prev_r_reg <= 32'd0;
            px_reg     <= 48'd0;
            py_reg     <= 48'd0;
            hd_reg     <= 32'd0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_MPT:  mpt_reg  <= cfg_wdata;
                    REG_IWS:  iws_reg  <= cfg_wdata[23:0];
                    REG_GAIN: gain_reg <= cfg_wdata[17:0];
                    default:  ;
                endcase
            end
            if (cmd.prep) begin
                prev_l_reg <= left_reg;
                prev_r_reg <= right_reg;
            end
            if (mul_done) begin
                case (cmd.op)
                    OP_XINC: px_reg <= px_reg + ((sneg_reg ^ cneg) ? -inc : inc);
                    OP_YINC: py_reg <= py_reg + ((sneg_reg ^ cneg) ? -inc : inc);
                    OP_HEAD: hd_reg <= tneg_reg ? hd_reg - hinc : hd_reg + hinc;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            left_reg  <= s_tdata[31:0];
            right_reg <= s_tdata[63:32];
            e_reg     <= s_tdata[87:64];
        end
        if (cmd.prep) begin
            sneg_reg <= sv[33];
            tneg_reg <= tv[33];
            smag_reg <= sv[33] ? 33'(-sv) : sv[32:0];
            tmag_reg <= tv[33] ? 33'(-tv) : tv[32:0];
        end
        if (mul_done) begin
            case (cmd.op)
                OP_DSUM: dmag_reg <= prod[63:1];
                OP_P1:   p1_reg   <= prod[63:0];
                OP_K:    k_reg    <= prod[41:0];
                OP_TURN: thmag_reg <= (|prod[127:95]) ? 63'h7FFF_FFFF_FFFF_FFFF : prod[94:32];
                OP_LSPD: n_reg[0] <= prod[82:16];
                OP_ASPD: n_reg[1] <= prod[82:16];
                default: ;
            endcase
        end
        if (cmd.commit) begin
            m_tdata <= {spd[1], spd[0], hd_reg, py_reg, px_reg};
            m_tuser <= (e_reg == 24'd0);
        end
    end

    assign sts.mul_done    = mul_done;
    assign sts.cordic_done = cordic_done;
    assign sts.div_done    = ddone_reg;

endmodule

// ===== rtl/core/diff_drive_odometry.sv =====
// Differential drive odometry, top level.
// Depends on ddo_pkg, ddo_ctrl and ddo_datapath.
//
// Each input word carries absolute left/right encoder counts and the elapsed time in
// microseconds; each yields one result word with the pose after the update and the
// saturated linear and angular speed (both zero, with the error flag set, when the
// elapsed time is zero). An item runs from acceptance through a prep step, then nine
// products in turn through one 32x32 multiplier (each: issue, four passes, accumulate,
// hand-back), then the 32-step divide of both speeds and the commit, with the 16-step
// CORDIC overlapping the first products. One item is in work at a time, so a new word
// is not taken before the last item is through; a new word is taken while the previous
// result still waits on the output, and a waiting result stalls the commit of the next.
// Registers must be written only while idle; the block itself does not enforce it.
module diff_drive_odometry import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int COUNT_BITS   = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // left_count, right_count, elapsed_time
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // pos_x, pos_y, heading_angle, linear_speed, turn_rate
    output logic [0:0]   m_tuser    // time_error
);
    ddo_cmd_t cmd;
    ddo_sts_t sts;

    ddo_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    ddo_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tdata(s_tdata), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cmd(cmd), .sts(sts)
    );

endmodule

// ===== dv/diff_drive_odometry_test.sv =====
// Self-checking bench for diff_drive_odometry: directed rows, then random encoder samples
// over several register settings, with an in-bench pose and speed predictor.
// Depends on ddo_pkg and the diff_drive_odometry RTL.
`timescale 1ns / 1ps

module diff_drive_odometry_test;
    import ddo_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped index, must be ignored
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RAND_PER_PHASE = 184;

    typedef struct packed {
        bit [47:0] x;
        bit [47:0] y;
        bit [31:0] hd;
        bit [31:0] lin;
        bit [31:0] rate;
        bit        err;
    } pose_t;

    typedef struct packed {
        bit [31:0] l;
        bit [31:0] r;
        bit [23:0] e;
        bit        chk;
        pose_t     want;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic [0:0]   m_tuser;

    // predictor state
    bit [31:0] mpt, iws, gain;
    bit [31:0] last_l, last_r, hd;
    bit [47:0] px, py;

    pose_t pose_q[$];
    int    errors = 0;
    int    cycles = 0;
    bit    quiet = 1'b0;

    row_t dir_rows[14] = '{
        '{32'd0, 32'd0, 24'd1, 1'b1, '0},
        '{32'd0, 32'd0, 24'd0, 1'b1, '{x: 0, y: 0, hd: 0, lin: 0, rate: 0, err: 1'b1}},
        '{32'd1000, 32'd1000, 24'd1000, 1'b0, '0},
        '{32'd2000, 32'd0, 24'd1, 1'b0, '0},
        '{32'd3000, 32'd3000, 24'd0, 1'b0, '0},
        '{32'h7fffffff, 32'h80000000, 24'hffffff, 1'b0, '0},
        '{32'h80000000, 32'h7fffffff, 24'd1, 1'b0, '0},
        '{32'hffffffff, 32'd0, 24'd500, 1'b0, '0},
        '{32'd0, 32'hffffffff, 24'd10, 1'b0, '0},
        '{32'h12345678, 32'h12345678, 24'd1, 1'b0, '0},
        '{32'h12345678, 32'h12345678, 24'hffffff, 1'b0, '0},
        '{32'h7fffffff, 32'h7fffffff, 24'd1, 1'b0, '0},
        '{32'h80000000, 32'h80000000, 24'd1, 1'b0, '0},
        '{32'h00001000, 32'h7ffff000, 24'd2, 1'b0, '0}
    };

    diff_drive_odometry u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic bit [31:0] speed_q16(bit [63:0] mag, bit neg, bit [23:0] e);
        bit [63:0] den, q, r, v, lim;
        den = 64'(e) << 16;
        q = mag / den;
        r = mag % den;
        lim = neg ? 64'h80000000 : 64'h7fffffff;
        if (q > 64'd2148) v = lim;
        else v = q * 64'd1000000 + (r * 64'd1000000) / den;
        if (v > lim) v = lim;
        return neg ? -v[31:0] : v[31:0];
    endfunction

    task automatic rotate_unit(input bit [31:0] ang, output longint c, output longint s);
        longint z, x, y, nx;
        bit flip;
        z = {32'b0, ang};
        x = longint'(CORDIC_X0);
        y = 0;
        flip = 1'b0;
        if (z >= 64'sh80000000) z -= 64'sh100000000;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000;
            flip = 1'b1;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TAB[i]);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic bit [47:0] step_axis(bit [47:0] pos, bit [63:0] dmag, bit dneg,
                                            longint comp);
        bit [127:0] a, b, p;
        bit neg;
        neg = dneg ^ (comp < 0);
        a = 128'(dmag);
        b = 128'((comp < 0) ? -comp : comp);
        p = a * b;
        return neg ? pos - p[93:46] : pos + p[93:46];
    endfunction

    task automatic predict_pose(input bit [31:0] l, r, input bit [23:0] e, output pose_t o);
        bit [31:0] dl, dr;
        longint cl, cr, s, t, cs, sn;
        bit sneg, tneg;
        bit [63:0] smag, tmag, dmag, p1, k, thmag;
        bit [127:0] a, b, w;
        dl = l - last_l;
        dr = r - last_r;
        cl = longint'($signed(dl));
        cr = longint'($signed(dr));
        s = cl + cr;
        t = cl - cr;
        sneg = s < 0;
        tneg = t < 0;
        smag = sneg ? -s : s;
        tmag = tneg ? -t : t;
        dmag = (smag * 64'(mpt)) >> 1;
        p1 = tmag * 64'(mpt);
        k = 64'(iws) * 64'(gain);
        a = 128'(p1);
        b = 128'(k);
        w = a * b;
        thmag = (w[127:64] >= 64'h80000000) ? 64'h7fffffffffffffff : w[95:32];
        rotate_unit(hd, cs, sn);
        px = step_axis(px, dmag, sneg, cs);
        py = step_axis(py, dmag, sneg, sn);
        a = 128'(thmag);
        b = 128'(INV_TWO_PI);
        w = a * b;
        hd = tneg ? hd - w[63:32] : hd + w[63:32];
        last_l = l;
        last_r = r;
        o.x = px;
        o.y = py;
        o.hd = hd;
        o.err = (e == 0);
        o.lin = o.err ? '0 : speed_q16(dmag, sneg && dmag != 0, e);
        o.rate = o.err ? '0 : speed_q16(thmag, tneg && thmag != 0, e);
    endtask

    task automatic report(string what, bit [63:0] got, bit [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [1:0] idx, bit [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MPT:  mpt = val;
            REG_IWS:  iws = val & 32'hffffff;
            REG_GAIN: gain = val & 32'h3ffff;
            default: ;
        endcase
    endtask

    // push one word; typed expectation overrides the predictor when given
    task automatic send_word(bit [31:0] l, r, bit [23:0] e, bit chk, pose_t want);
        pose_t p;
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < 29) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {e, r, l};
        do @(posedge aclk); while (!s_tready);
        predict_pose(l, r, e, p);
        pose_q.push_back(chk ? want : p);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_random();
        int pick;
        bit [31:0] l, r;
        bit [23:0] e;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            // plausible motion: both wheels step a little from the last sample
            l = last_l + $urandom_range(0, 4000) - 2000;
            r = last_r + $urandom_range(0, 4000) - 2000;
        end else if (pick < 85) begin
            l = last_l + $urandom_range(0, 400) - 200;
            r = l - last_l + last_r + $urandom_range(0, 20) - 10;
        end else begin
            l = $urandom;
            r = $urandom;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) e = '0;
        else if (pick < 10) e = 24'hffffff;
        else if (pick < 15) e = 24'($urandom_range(1, 3));
        else if (pick < 25) e = 24'($urandom);
        else e = 24'($urandom_range(200, 50000));
        send_word(l, r, e, 1'b0, '0);
    endtask

    task automatic wait_idle();
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(negedge aclk)
        m_tready <= quiet || ($urandom_range(0, 99) >= 29);

    always @(posedge aclk) begin
        pose_t w;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pose_q.size() == 0) begin
                report("unexpected word", m_tdata[63:0], '0);
            end else begin
                w = pose_q.pop_front();
                if (m_tdata[47:0] !== w.x) report("pos_x", m_tdata[47:0], w.x);
                if (m_tdata[95:48] !== w.y) report("pos_y", m_tdata[95:48], w.y);
                if (m_tdata[127:96] !== w.hd) report("heading", m_tdata[127:96], w.hd);
                if (m_tdata[159:128] !== w.lin) report("linear", m_tdata[159:128], w.lin);
                if (m_tdata[191:160] !== w.rate) report("turn", m_tdata[191:160], w.rate);
                if (m_tuser[0] !== w.err) report("time_error", 64'(m_tuser[0]), 64'(w.err));
            end
        end
    end

    initial begin
        mpt = MPT_RST;
        iws = 32'(IWS_RST);
        gain = 32'(GAIN_RST);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].l, dir_rows[i].r, dir_rows[i].e, dir_rows[i].chk,
                      dir_rows[i].want);
        repeat (RAND_PER_PHASE) send_random();
        wait_idle();

        // all registers at full scale: huge turns and saturated speeds
        write_reg(REG_MPT, 32'hffffffff);
        write_reg(REG_IWS, 32'hffffff);
        write_reg(REG_GAIN, 32'h3ffff);
        write_reg(REG_SPARE, 32'h12345678);
        repeat (RAND_PER_PHASE) send_random();
        wait_idle();

        write_reg(REG_MPT, 32'd0);
        write_reg(REG_IWS, 32'd0);
        write_reg(REG_GAIN, 32'd0);
        repeat (RAND_PER_PHASE / 2) send_random();
        wait_idle();

        // no back-pressure or gaps in this stretch
        quiet = 1'b1;
        write_reg(REG_MPT, MPT_RST);
        write_reg(REG_IWS, 32'(IWS_RST));
        write_reg(REG_GAIN, 32'(GAIN_RST));
        repeat (RAND_PER_PHASE) send_random();
        wait_idle();
        quiet = 1'b0;

        for (int ph = 0; ph < 2; ph++) begin
            write_reg(REG_MPT, $urandom);
            write_reg(REG_IWS, $urandom);
            write_reg(REG_GAIN, $urandom);
            repeat (RAND_PER_PHASE / 2) send_random();
            wait_idle();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
